FILE: sv/tpt_pkg.sv
`default_nettype none
package tpt_pkg;

  // table geometry
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // frame format
  localparam logic [7:0] HDR_BYTE0     = 8'h1B;
  localparam logic [7:0] HDR_BYTE1     = 8'h39;
  localparam logic [7:0] HDR_BYTE2     = 8'h01;
  localparam logic [3:0] POS_HDR0      = 4'd0;
  localparam logic [3:0] POS_HDR1      = 4'd1;
  localparam logic [3:0] POS_HDR2      = 4'd2;
  localparam logic [3:0] POS_SIGNAL    = 4'd7;
  localparam logic [3:0] POS_BATTERY   = 4'd9;
  localparam logic [3:0] POS_ID_FIRST  = 4'd10;
  localparam logic [3:0] POS_ID_LAST   = 4'd13;
  localparam logic [3:0] MIN_FRAME_LEN = 4'd14;
  localparam logic [3:0] COUNT_MAX     = 4'd15;

  localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

  // input operation codes
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_SWEEP = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_UPDATED  = 3'd0;
  localparam logic [2:0] STAT_NEW      = 3'd1;
  localparam logic [2:0] STAT_REJECTED = 3'd2;
  localparam logic [2:0] STAT_FULL     = 3'd3;
  localparam logic [2:0] STAT_SWEEP    = 3'd4;

  typedef enum logic [1:0] {
    CMD_FRAME_OK,
    CMD_FRAME_BAD,
    CMD_SWEEP
  } cmd_kind_t;

  // one classified command for the table engine
  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] id;
    logic [7:0]  sig;
    logic [7:0]  bat;
    logic [31:0] tick;
  } cmd_t;

endpackage
`default_nettype wire

FILE: sv/tpt_front.sv
`default_nettype none
module tpt_front
  import tpt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_operation,
  input  wire logic [7:0] in_frame_byte,
  input  wire logic       in_frame_end,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_cmd
);

  logic [3:0]  byte_count_r, byte_count_nxt;
  logic        header_ok_r, header_ok_nxt;
  logic [7:0]  rx_signal_r, rx_signal_nxt;
  logic [7:0]  rx_battery_r, rx_battery_nxt;
  logic [31:0] rx_id_r, rx_id_nxt;
  logic [31:0] tick_r;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // byte capture and header check
  always_comb begin
    byte_count_nxt = byte_count_r;
    header_ok_nxt  = header_ok_r;
    rx_signal_nxt  = rx_signal_r;
    rx_battery_nxt = rx_battery_r;
    rx_id_nxt      = rx_id_r;
    if (byte_count_r == POS_HDR0 && in_frame_byte != HDR_BYTE0) header_ok_nxt = 1'b0;
    if (byte_count_r == POS_HDR1 && in_frame_byte != HDR_BYTE1) header_ok_nxt = 1'b0;
    if (byte_count_r == POS_HDR2 && in_frame_byte != HDR_BYTE2) header_ok_nxt = 1'b0;
    if (byte_count_r == POS_SIGNAL) rx_signal_nxt = in_frame_byte;
    if (byte_count_r == POS_BATTERY) rx_battery_nxt = in_frame_byte;
    if (byte_count_r >= POS_ID_FIRST && byte_count_r <= POS_ID_LAST) begin
      rx_id_nxt = {rx_id_r[23:0], in_frame_byte};
    end
    if (byte_count_r < COUNT_MAX) byte_count_nxt = byte_count_r + 4'd1;
  end

  // classify into a queue command
  always_comb begin
    q_push     = 1'b0;
    q_cmd.kind = CMD_SWEEP;
    q_cmd.id   = rx_id_nxt;
    q_cmd.sig  = rx_signal_nxt;
    q_cmd.bat  = rx_battery_nxt;
    q_cmd.tick = tick_r;
    if (accept) begin
      case (in_operation)
        OP_BYTE: begin
          if (in_frame_end) begin
            q_push = 1'b1;
            if (byte_count_nxt >= MIN_FRAME_LEN && header_ok_nxt) begin
              q_cmd.kind = CMD_FRAME_OK;
            end else begin
              q_cmd.kind = CMD_FRAME_BAD;
            end
          end
        end
        OP_SWEEP: q_push = 1'b1;
        default: q_push = 1'b0;
      endcase
    end
  end

  // capture state and time base
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      header_ok_r  <= 1'b1;
      rx_signal_r  <= '0;
      rx_battery_r <= '0;
      rx_id_r      <= '0;
      tick_r       <= '0;
    end else if (accept) begin
      case (in_operation)
        OP_BYTE: begin
          if (in_frame_end) begin
            byte_count_r <= '0;
            header_ok_r  <= 1'b1;
            rx_signal_r  <= '0;
            rx_battery_r <= '0;
            rx_id_r      <= '0;
          end else begin
            byte_count_r <= byte_count_nxt;
            header_ok_r  <= header_ok_nxt;
            rx_signal_r  <= rx_signal_nxt;
            rx_battery_r <= rx_battery_nxt;
            rx_id_r      <= rx_id_nxt;
          end
        end
        OP_TICK: tick_r <= tick_r + 32'd1;
        default: tick_r <= tick_r;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/tpt_fifo.sv
`default_nettype none
module tpt_fifo
  import tpt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      empty
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/tpt_back.sv
`default_nettype none
module tpt_back
  import tpt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_wdata,
  input  wire logic              q_empty,
  input  wire cmd_t              q_cmd,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_status,
  output logic [SLOT_W-1:0]      out_slot,
  output logic                   out_slot_valid,
  output logic [31:0]            out_tag_id,
  output logic [7:0]             out_signal_level,
  output logic [7:0]             out_battery_level,
  output logic                   out_went_offline,
  output logic [SLOT_COUNT-1:0]  out_valid_map,
  output logic                   out_last_row
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t                state_r;
  logic [SLOT_W-1:0]     row_r;
  logic [2:0]            status_r;
  logic [SLOT_COUNT-1:0] valid_r;
  logic [SLOT_COUNT-1:0] removed_r;
  logic [31:0]           timeout_r;
  logic [31:0]           ids_r  [SLOT_COUNT];
  logic [7:0]            sigs_r [SLOT_COUNT];
  logic [7:0]            bats_r [SLOT_COUNT];
  logic [31:0]           seen_r [SLOT_COUNT];

  logic                  hit_any;
  logic [SLOT_W-1:0]     hit_idx;
  logic                  free_any;
  logic [SLOT_W-1:0]     free_idx;
  logic [SLOT_COUNT-1:0] stale;
  logic                  row_valid;

  assign q_pop = (state_r == ST_IDLE) && !q_empty;

  // id match and lowest free slot, lowest index wins
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (valid_r[i] && ids_r[i] == q_cmd.id) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  // per-slot age check, wrapping difference
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      stale[i] = valid_r[i] && ((q_cmd.tick - seen_r[i]) > timeout_r);
    end
  end

  // timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // command execution and row sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      row_r     <= '0;
      status_r  <= STAT_REJECTED;
      valid_r   <= '0;
      removed_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            state_r   <= ST_EMIT;
            row_r     <= '0;
            removed_r <= '0;
            case (q_cmd.kind)
              CMD_FRAME_OK: begin
                if (hit_any) begin
                  status_r        <= STAT_UPDATED;
                  sigs_r[hit_idx] <= q_cmd.sig;
                  bats_r[hit_idx] <= q_cmd.bat;
                  seen_r[hit_idx] <= q_cmd.tick;
                end else if (free_any) begin
                  status_r          <= STAT_NEW;
                  valid_r[free_idx] <= 1'b1;
                  ids_r[free_idx]   <= q_cmd.id;
                  sigs_r[free_idx]  <= q_cmd.sig;
                  bats_r[free_idx]  <= q_cmd.bat;
                  seen_r[free_idx]  <= q_cmd.tick;
                end else begin
                  status_r <= STAT_FULL;
                end
              end
              CMD_SWEEP: begin
                status_r  <= STAT_SWEEP;
                valid_r   <= valid_r & ~stale;
                removed_r <= stale;
              end
              default: status_r <= STAT_REJECTED;
            endcase
          end
        end
        ST_EMIT: begin
          if (out_ready) begin
            if (row_r == SLOT_W'(SLOT_COUNT - 1)) begin
              state_r <= ST_IDLE;
            end else begin
              row_r <= row_r + SLOT_W'(1);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // row image, empty slots read zero id, signal and battery levels
  assign row_valid         = valid_r[row_r];
  assign out_valid         = (state_r == ST_EMIT);
  assign out_status        = status_r;
  assign out_slot          = row_r;
  assign out_slot_valid    = row_valid;
  assign out_tag_id        = row_valid ? ids_r[row_r] : '0;
  assign out_signal_level  = row_valid ? sigs_r[row_r] : '0;
  assign out_battery_level = row_valid ? bats_r[row_r] : '0;
  assign out_went_offline  = removed_r[row_r];
  assign out_valid_map     = valid_r;
  assign out_last_row      = (row_r == SLOT_W'(SLOT_COUNT - 1));

endmodule
`default_nettype wire

FILE: sv/tag_presence_table.sv
// output: a frame end or sweep transaction passes through the command queue
// and the table update before its first row, then one row per cycle while
// out_ready is high. The table engine takes no new command until its 8th row
// is taken; the queue holds up to 2 commands and input waits while it is full.
// reset: synchronous active-low; clears table valid bits, capture state, tick
// count and queue, and loads the offline timeout with 5000.
`default_nettype none
module tag_presence_table
  import tpt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_frame_byte,
  input  wire logic        in_frame_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [2:0]       out_slot,
  output logic             out_slot_valid,
  output logic [31:0]      out_tag_id,
  output logic [7:0]       out_signal_level,
  output logic [7:0]       out_battery_level,
  output logic             out_went_offline,
  output logic [7:0]       out_valid_map,
  output logic             out_last_row
);

  logic q_full;
  logic q_push;
  logic q_empty;
  logic q_pop;
  cmd_t q_in;
  cmd_t q_out;

  // byte capture and classification
  tpt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_frame_byte (in_frame_byte),
    .in_frame_end  (in_frame_end),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_in)
  );

  // command queue
  tpt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // table update and row output
  tpt_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .q_empty           (q_empty),
    .q_cmd             (q_out),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_slot_valid    (out_slot_valid),
    .out_tag_id        (out_tag_id),
    .out_signal_level  (out_signal_level),
    .out_battery_level (out_battery_level),
    .out_went_offline  (out_went_offline),
    .out_valid_map     (out_valid_map),
    .out_last_row      (out_last_row)
  );

endmodule
`default_nettype wire
